// File: src/mon_pkg.sv
// ----------------------------------------------------------------------------
// Matrix one-norm package
// Shared constants, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package mon_pkg;

	localparam int MAX_N  = 64;
	localparam int IDX_W  = $clog2(MAX_N);
	localparam int SIZE_W = 7;
	localparam int ELEM_W = 32;
	localparam int SUM_W  = 38;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_N);
	localparam logic [SUM_W-1:0]  SUM_SAT    = {SUM_W{1'b1}};

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic final_elem;
		logic out_full;
	} dp_status_t;

endpackage

// File: src/matrix_one_norm_top.sv
// ----------------------------------------------------------------------------
// Matrix one-norm top level
// Largest column sum of absolute values of a square Q16.16 matrix.
// ----------------------------------------------------------------------------
// Elements enter on the in_valid/in_ready channel in row-major order, one per
// transfer. Each element passes through a capture state that reads its column
// accumulator from the single-port column memory and an accumulate state
// that adds its magnitude and writes the sum back, so in_ready is low while
// an element accumulates. The accumulate step of the last element of a
// matrix loads the norm into the output register and raises out_valid with
// it, and the norm holds until taken on the out_valid/out_ready channel.
// While a result waits, elements of the next matrix are still accepted; only
// the final element of that next matrix waits in its accumulate cycle until
// the pending result is taken. A write on cfg_wr_en sets the matrix size
// (0 acts as 1, above 64 acts as 64) and abandons any partial matrix.
// Reset sets the size to 64 and clears indices, maximum and per-column
// valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix_one_norm_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mon_pkg::SIZE_W-1:0]        cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [mon_pkg::ELEM_W-1:0] element,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mon_pkg::SUM_W-1:0]         norm
);

	mon_pkg::dp_cmd_t    cmd;
	mon_pkg::dp_status_t status;

	mon_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mon_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.element     (element),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.norm        (norm)
	);

endmodule

// File: src/mon_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix one-norm controller
// Sequences each element through capture and accumulate.
// ----------------------------------------------------------------------------
module mon_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mon_pkg::dp_status_t status,
	output mon_pkg::dp_cmd_t    cmd
);

	mon_pkg::state_t state_q;
	mon_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mon_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mon_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mon_pkg::ST_ACC;
				end
			end
			mon_pkg::ST_ACC: begin
				if (!(status.final_elem && status.out_full)) begin
					state_d = mon_pkg::ST_IDLE;
				end
			end
			default: state_d = mon_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			mon_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			mon_pkg::ST_ACC: begin
				cmd.commit = !(status.final_elem && status.out_full);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: src/mon_dp.sv
// ----------------------------------------------------------------------------
// Matrix one-norm datapath
// Column accumulator memory, indices, running maximum and result register.
// ----------------------------------------------------------------------------
module mon_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mon_pkg::SIZE_W-1:0]          cfg_wr_data,
	input  logic signed [mon_pkg::ELEM_W-1:0]   element,
	input  mon_pkg::dp_cmd_t                    cmd,
	output mon_pkg::dp_status_t                 status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mon_pkg::SUM_W-1:0]           norm
);

	logic [mon_pkg::SIZE_W-1:0] size_q;
	logic [mon_pkg::IDX_W-1:0]  col_q;
	logic [mon_pkg::IDX_W-1:0]  row_q;
	logic [mon_pkg::SUM_W-1:0]  max_q;
	logic [mon_pkg::MAX_N-1:0]  valid_q;
	logic [mon_pkg::SUM_W-1:0]  norm_q;
	logic                       out_valid_q;

	logic [mon_pkg::ELEM_W-1:0] mag_s1;
	logic [mon_pkg::IDX_W-1:0]  col_s1;
	logic                       last_row_s1;
	logic                       last_col_s1;
	logic [mon_pkg::SUM_W-1:0]  rd_s1;
	logic                       hit_s1;

	logic [mon_pkg::SUM_W-1:0]  mem [mon_pkg::MAX_N];

	logic [mon_pkg::SIZE_W-1:0] n_eff;
	logic [mon_pkg::SIZE_W-1:0] n_last;
	logic [mon_pkg::IDX_W-1:0]  col_idx;
	logic [mon_pkg::ELEM_W-1:0] mag;
	logic [mon_pkg::SUM_W-1:0]  base;
	logic [mon_pkg::SUM_W:0]    sum_wide;
	logic [mon_pkg::SUM_W-1:0]  sum;
	logic [mon_pkg::SUM_W-1:0]  max_next;
	logic                       final_elem;

	always_comb begin
		if (size_q == '0) begin
			n_eff = mon_pkg::SIZE_W'(1);
		end else if (size_q > mon_pkg::SIZE_MAX) begin
			n_eff = mon_pkg::SIZE_MAX;
		end else begin
			n_eff = size_q;
		end
		n_last  = n_eff - mon_pkg::SIZE_W'(1);
		col_idx = (mon_pkg::SIZE_W'(col_q) >= n_eff) ? '0 : col_q;
		mag     = element[mon_pkg::ELEM_W-1] ? (~element + 1'b1) : element;
	end

	always_comb begin
		base     = hit_s1 ? rd_s1 : '0;
		sum_wide = {1'b0, base} + (mon_pkg::SUM_W+1)'(mag_s1);
		sum      = sum_wide[mon_pkg::SUM_W] ? mon_pkg::SUM_SAT : sum_wide[mon_pkg::SUM_W-1:0];
		max_next = (last_row_s1 && (sum > max_q)) ? sum : max_q;
		final_elem = last_row_s1 && last_col_s1;
	end

	assign status.final_elem = final_elem;
	assign status.out_full   = out_valid_q && !out_ready;
	assign out_valid         = out_valid_q;
	assign norm              = norm_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && !last_row_s1) begin
			mem[col_s1] <= sum;
		end
		if (cmd.capture) begin
			rd_s1 <= mem[col_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_s1      <= mag;
			col_s1      <= col_idx;
			last_row_s1 <= mon_pkg::SIZE_W'(row_q) >= n_last;
			last_col_s1 <= mon_pkg::SIZE_W'(col_idx) >= n_last;
			hit_s1      <= valid_q[col_idx];
		end
		if (cmd.commit && final_elem) begin
			norm_q <= max_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= mon_pkg::SIZE_RESET;
			col_q       <= '0;
			row_q       <= '0;
			max_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				size_q  <= cfg_wr_data;
				col_q   <= '0;
				row_q   <= '0;
				max_q   <= '0;
				valid_q <= '0;
			end else if (cmd.commit) begin
				valid_q[col_s1] <= !last_row_s1;
				if (final_elem) begin
					out_valid_q <= 1'b1;
					col_q       <= '0;
					row_q       <= '0;
					max_q       <= '0;
				end else begin
					max_q <= max_next;
					if (last_col_s1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_s1 + 1'b1;
					end
				end
			end
		end
	end

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && final_elem && !cfg_wr_en |=> out_valid_q)
		else $error("finished matrix did not raise the result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && final_elem && out_valid_q && !out_ready))
		else $error("pending result overwritten");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mon_pkg::SIZE_W'(col_q) < n_eff)
		else $error("column index beyond matrix size");

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && final_elem |=> (row_q == '0) && (col_q == '0) && (max_q == '0))
		else $error("state not cleared after matrix");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

endmodule
